// ===== sv/sfoc_pkg.sv =====
package sfoc_pkg;

    typedef struct packed {
        logic [11:0] field_offset;
        logic [12:0] field_size;
        logic        first_field;
        logic        last_field;
    } t_sfoc_in;

    typedef struct packed {
        logic       field_accepted;
        logic [1:0] error_code;
        logic       layout_valid;
        logic       layout_done;
    } t_sfoc_out;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_BOUNDS  = 2'd1;
    localparam logic [1:0] ERR_OVERLAP = 2'd2;

    // register index decoded from paddr[2]
    localparam logic REG_STRUCT_LENGTH = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD,
        S_CHK,
        S_MRD,
        S_MWR,
        S_FIN
    } t_sfoc_state;

    typedef struct packed {
        logic load;
        logic div;
        logic rd;
        logic adv;
        logic rewind;
        logic wr;
        logic set_ovl;
        logic emit;
    } t_sfoc_cmd;

    typedef struct packed {
        logic oob;
        logic zero;
        logic overlap;
        logic last_word;
    } t_sfoc_status;

endpackage

// ===== sv/sfoc_ram.sv =====
module sfoc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                          i_wdata,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/sfoc_ctrl.sv =====
module sfoc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  sfoc_pkg::t_sfoc_status i_status,
    output sfoc_pkg::t_sfoc_cmd    o_cmd
);
    import sfoc_pkg::*;

    t_sfoc_state r_state, n_state;
    logic        r_out_valid, n_out_valid;
    logic        out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_DIV;
            S_DIV: begin
                if (i_status.oob || i_status.zero) n_state = S_FIN;
                else n_state = S_RD;
            end
            S_RD: n_state = S_CHK;
            S_CHK: begin
                if (i_status.overlap) n_state = S_FIN;
                else if (i_status.last_word) n_state = S_MRD;
                else n_state = S_RD;
            end
            S_MRD: n_state = S_MWR;
            S_MWR: begin
                if (i_status.last_word) n_state = S_FIN;
                else n_state = S_MRD;
            end
            S_FIN: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DIV: o_cmd.div = 1'b1;
            S_RD:  o_cmd.rd = 1'b1;
            S_CHK: begin
                if (i_status.overlap) o_cmd.set_ovl = 1'b1;
                else if (i_status.last_word) o_cmd.rewind = 1'b1;
                else o_cmd.adv = 1'b1;
            end
            S_MRD: o_cmd.rd = 1'b1;
            S_MWR: begin
                o_cmd.wr  = 1'b1;
                o_cmd.adv = !i_status.last_word;
            end
            S_FIN: o_cmd.emit = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    assign o_out_valid = r_out_valid;
endmodule

// ===== sv/sfoc_dp.sv =====
module sfoc_dp #(
    parameter int MAX_STRUCT_BYTES = 4096,
    parameter int SEGMENT_BITS     = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [12:0]            i_struct_length,
    input  sfoc_pkg::t_sfoc_in     i_in_data,
    input  sfoc_pkg::t_sfoc_cmd    i_cmd,
    output sfoc_pkg::t_sfoc_status o_status,
    output sfoc_pkg::t_sfoc_out    o_out_data
);
    import sfoc_pkg::*;

    localparam int MAP_WORDS = (MAX_STRUCT_BYTES + SEGMENT_BITS - 1) / SEGMENT_BITS;
    localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BX        = $clog2(MAP_WORDS * SEGMENT_BITS + SEGMENT_BITS + 1);
    localparam int BW        = (BX > 13) ? BX : 13;
    localparam int LW        = $clog2(SEGMENT_BITS + 1);
    // exact floor(offset / SEGMENT_BITS) for 12-bit offsets by reciprocal multiply
    localparam int SH        = 12 + $clog2(SEGMENT_BITS);
    localparam int RECIP     = ((1 << SH) + SEGMENT_BITS - 1) / SEGMENT_BITS;
    localparam int PW        = SH + 12;

    logic [11:0]             r_off;
    logic [12:0]             r_end;
    logic                    r_last;
    logic [11:0]             r_q;
    logic                    r_oob;
    logic                    r_zero;
    logic [1:0]              r_err;
    logic                    r_failed;
    logic [MAP_WORDS-1:0]    r_wvalid;
    logic [WW-1:0]           r_w, r_w0;
    logic [BW-1:0]           r_base, r_base0;
    logic [SEGMENT_BITS-1:0] r_mask;
    logic                    r_lastw;
    t_sfoc_out               r_out;

    logic [12:0]             end_sum;
    logic [12:0]             limit;
    logic [PW-1:0]           prod;
    logic [BW-1:0]           off_x, end_x, top;
    logic [LW-1:0]           lo, hi;
    logic [SEGMENT_BITS-1:0] mask;
    logic [SEGMENT_BITS-1:0] rdata, word;
    logic [BW-1:0]           q_base;

    assign end_sum = 13'(i_in_data.field_offset) + i_in_data.field_size;
    assign limit   = (int'(i_struct_length) > MAX_STRUCT_BYTES) ?
                     13'(MAX_STRUCT_BYTES) : i_struct_length;
    assign prod    = PW'(i_in_data.field_offset) * PW'(RECIP);
    assign q_base  = BW'(r_q) * BW'(SEGMENT_BITS);

    // span of the field inside the word at r_base
    assign off_x = BW'(r_off);
    assign end_x = BW'(r_end);
    assign top   = r_base + BW'(SEGMENT_BITS);
    assign lo    = (off_x > r_base) ? LW'(off_x - r_base) : '0;
    assign hi    = (end_x < top) ? LW'(end_x - r_base) : LW'(SEGMENT_BITS);
    assign mask  = ~({SEGMENT_BITS{1'b1}} << hi) & ({SEGMENT_BITS{1'b1}} << lo);

    // a word not yet written in this layout reads as zero
    assign word = r_wvalid[r_w] ? rdata : '0;

    sfoc_ram #(
        .WIDTH(SEGMENT_BITS),
        .DEPTH(MAP_WORDS)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr),
        .i_addr (r_w),
        .i_wdata(word | r_mask),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= '0;
            r_failed <= 1'b0;
        end else begin
            if (i_cmd.load && i_in_data.first_field) begin
                r_wvalid <= '0;
                r_failed <= 1'b0;
            end
            if (i_cmd.wr) r_wvalid[r_w] <= 1'b1;
            if (i_cmd.emit && r_err != ERR_NONE) r_failed <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_off  <= i_in_data.field_offset;
            r_end  <= end_sum;
            r_last <= i_in_data.last_field;
            r_q    <= prod[SH +: 12];
            r_oob  <= end_sum > limit;
            r_zero <= i_in_data.field_size == '0;
            r_err  <= (end_sum > limit) ? ERR_BOUNDS : ERR_NONE;
        end
        if (i_cmd.set_ovl) r_err <= ERR_OVERLAP;
        if (i_cmd.div) begin
            r_w0    <= WW'(r_q);
            r_w     <= WW'(r_q);
            r_base0 <= q_base;
            r_base  <= q_base;
        end
        if (i_cmd.rd) begin
            r_mask  <= mask;
            r_lastw <= top >= end_x;
        end
        if (i_cmd.adv) begin
            r_w    <= r_w + WW'(1);
            r_base <= top;
        end
        if (i_cmd.rewind) begin
            r_w    <= r_w0;
            r_base <= r_base0;
        end
        if (i_cmd.emit) begin
            r_out.field_accepted <= r_err == ERR_NONE;
            r_out.error_code     <= r_err;
            r_out.layout_valid   <= !r_failed && r_err == ERR_NONE;
            r_out.layout_done    <= r_last;
        end
    end

    assign o_status.oob       = r_oob;
    assign o_status.zero      = r_zero;
    assign o_status.overlap   = |(word & r_mask);
    assign o_status.last_word = r_lastw;
    assign o_out_data         = r_out;
endmodule

// ===== sv/struct_field_overlap_checker.sv =====
// An empty or out-of-bounds field goes straight from the divide step to the result;
// otherwise each spanned word costs a read/check pair, stopping at an overlap, then
// a read/write pair on the single bitmap RAM port. A new field is accepted only in
// the idle state, once the result word of the last one is registered for output.
// Reset (synchronous, active low) clears the controller, the per-word valid bits,
// the failure flag and struct_length; bitmap RAM contents are not cleared.
module struct_field_overlap_checker #(
    parameter int MAX_STRUCT_BYTES = 4096,
    parameter int SEGMENT_BITS     = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sfoc_pkg::t_sfoc_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sfoc_pkg::t_sfoc_out o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import sfoc_pkg::*;

    logic [12:0]  r_struct_length;
    t_sfoc_cmd    cmd;
    t_sfoc_status status;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_struct_length <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_STRUCT_LENGTH) begin
            r_struct_length <= pwdata[12:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_STRUCT_LENGTH) prdata = {19'd0, r_struct_length};
    end

    sfoc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sfoc_dp #(
        .MAX_STRUCT_BYTES(MAX_STRUCT_BYTES),
        .SEGMENT_BITS    (SEGMENT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_struct_length(r_struct_length),
        .i_in_data      (i_in_data),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_data     (o_out_data)
    );
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import sfoc_pkg::*;

    localparam int MAP_BYTES = 4096;
    localparam int HOLD_CYCLES = 600;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_sfoc_in    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_sfoc_out   o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    always #4 i_clk = ~i_clk;

    struct_field_overlap_checker uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // byte occupancy of the layout in progress
    bit [MAP_BYTES-1:0] byte_taken = '0;
    bit                 layout_broken = 1'b0;
    logic [12:0]        struct_len = '0;

    t_sfoc_in  field_q[$];
    t_sfoc_out verdict_q[$];
    t_sfoc_out want;

    int gap_pct = 0;
    int stall_pct = 0;
    bit hold_on = 1'b0;
    int fail_cnt = 0;

    function automatic int length_limit();
        return (struct_len > MAP_BYTES) ? MAP_BYTES : int'(struct_len);
    endfunction

    function automatic t_sfoc_out predict_verdict(t_sfoc_in f);
        int        fend;
        t_sfoc_out r;
        fend = int'(f.field_offset) + int'(f.field_size);
        r.error_code = ERR_NONE;
        if (f.first_field) begin
            byte_taken = '0;
            layout_broken = 1'b0;
        end
        if (fend > length_limit()) begin
            r.error_code = ERR_BOUNDS;
        end else begin
            // every byte is checked before any is claimed
            for (int b = f.field_offset; b < fend; b++)
                if (byte_taken[b]) r.error_code = ERR_OVERLAP;
            if (r.error_code == ERR_NONE)
                for (int b = f.field_offset; b < fend; b++) byte_taken[b] = 1'b1;
        end
        if (r.error_code != ERR_NONE) layout_broken = 1'b1;
        r.field_accepted = (r.error_code == ERR_NONE);
        r.layout_valid = !layout_broken;
        r.layout_done = f.last_field;
        return r;
    endfunction

    // sender: verdict is predicted when the word is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                verdict_q.insert(verdict_q.size(), predict_verdict(i_in_data));
            if (!i_in_valid || o_in_ready) begin
                if (field_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= field_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !hold_on && ($urandom_range(0, 99) >= stall_pct);
            if (o_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("result word with no field pending");
                    fail_cnt++;
                end else begin
                    want = verdict_q.pop_front();
                    if (o_out_data.field_accepted !== want.field_accepted) begin
                        $error("field_accepted: expected %0d, got %0d",
                               want.field_accepted, o_out_data.field_accepted);
                        fail_cnt++;
                    end
                    if (o_out_data.error_code !== want.error_code) begin
                        $error("error_code: expected %0d, got %0d",
                               want.error_code, o_out_data.error_code);
                        fail_cnt++;
                    end
                    if (o_out_data.layout_valid !== want.layout_valid) begin
                        $error("layout_valid: expected %0d, got %0d",
                               want.layout_valid, o_out_data.layout_valid);
                        fail_cnt++;
                    end
                    if (o_out_data.layout_done !== want.layout_done) begin
                        $error("layout_done: expected %0d, got %0d",
                               want.layout_done, o_out_data.layout_done);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    task automatic write_length(input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_STRUCT_LENGTH, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        struct_len = value[12:0];
    endtask

    task automatic push_field(input int off, input int sz, input bit fst, input bit lst);
        t_sfoc_in f;
        f.field_offset = off[11:0];
        f.field_size = sz[12:0];
        f.first_field = fst;
        f.last_field = lst;
        field_q.insert(field_q.size(), f);
    endtask

    // mostly packed layouts, with overlaps, tail-fitting fields and noise mixed in
    task automatic queue_layout(output int n);
        int cursor;
        int off;
        int sz;
        int pick;
        int lim;
        bit fst;
        bit lst;
        lim = length_limit();
        n = $urandom_range(1, 12);
        cursor = $urandom_range(0, 64);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                sz = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 96);
                off = cursor + $urandom_range(0, 8);
                cursor = off + sz;
            end else if (pick < 74) begin
                off = (cursor > 0) ? $urandom_range(0, cursor - 1) : 0;
                sz = $urandom_range(1, 32);
            end else if (pick < 82) begin
                sz = $urandom_range(1, 64);
                off = (lim >= sz) ? lim - sz : 0;
                off += $urandom_range(0, 1);
            end else if (pick < 92) begin
                off = $urandom_range(0, 4095);
                sz = $urandom_range(0, 4096);
            end else begin
                off = $urandom_range(0, 4095);
                sz = 0;
            end
            fst = (i == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 49) == 0);
            lst = (i == n - 1) ? 1'b1 : ($urandom_range(0, 19) == 0);
            push_field(off & 12'hFFF, sz, fst, lst);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (field_q.size() != 0 || i_in_valid || verdict_q.size() != 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [31:0] len, input int gap, input int stall,
                             input int nfields, input bit hold);
        int queued;
        int n;
        write_length(len);
        @(negedge i_clk);
        gap_pct = gap;
        stall_pct = stall;
        queued = 0;
        while (queued < nfields) begin
            queue_layout(n);
            queued += n;
        end
        if (hold) begin
            hold_on = 1'b1;
            repeat (HOLD_CYCLES) @(negedge i_clk);
            hold_on = 1'b0;
        end
        drain();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_length(32'd4096);
        @(negedge i_clk);
        // no first_field yet: map is empty after reset
        push_field(10, 5, 1'b0, 1'b0);
        push_field(12, 1, 1'b0, 1'b0);
        push_field(0, 0, 1'b1, 1'b0);
        push_field(0, 4096, 1'b0, 1'b0);
        push_field(4095, 1, 1'b0, 1'b1);
        push_field(4095, 1, 1'b1, 1'b0);
        push_field(4095, 0, 1'b0, 1'b0);
        push_field(0, 4096, 1'b0, 1'b0);
        push_field(4095, 2, 1'b0, 1'b0);
        push_field(4095, 4096, 1'b0, 1'b1);
        // word-crossing fields
        push_field(60, 10, 1'b1, 1'b0);
        push_field(64, 1, 1'b0, 1'b0);
        push_field(70, 58, 1'b0, 1'b0);
        push_field(128, 64, 1'b0, 1'b0);
        push_field(59, 1, 1'b0, 1'b0);
        push_field(192, 3904, 1'b0, 1'b1);
        push_field(2730, 1365, 1'b1, 1'b0);
        push_field(1365, 1365, 1'b0, 1'b0);
        push_field(0, 1365, 1'b0, 1'b1);
        push_field(0, 0, 1'b1, 1'b1);
        drain();

        run_phase(32'd0, 52, 0, 150, 1'b0);
        run_phase(32'hFFFF_FFFF, 0, 52, 250, 1'b0);
        run_phase(32'd64, 20, 20, 150, 1'b0);
        run_phase(32'd4096, 0, 0, 300, 1'b1);
        run_phase($urandom_range(1, 4096), 52, 0, 250, 1'b0);
        run_phase(32'd4097, 0, 52, 250, 1'b0);
        run_phase($urandom_range(1, 8191), 20, 20, 250, 1'b0);
        run_phase(32'd4095, 0, 0, 250, 1'b0);

        repeat (300) @(negedge i_clk);
        if (fail_cnt == 0 && verdict_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            if (verdict_q.size() != 0) $error("%0d verdicts never arrived", verdict_q.size());
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== struct_field_overlap_checker.f =====
sv/sfoc_pkg.sv
sv/sfoc_ram.sv
sv/sfoc_ctrl.sv
sv/sfoc_dp.sv
sv/struct_field_overlap_checker.sv
test/testbench.sv
